### hw/rtl/hash_topk_expert_router_top_macros.svh
// ============================================================================
// hash_topk_expert_router_top_macros.svh
// Assertion macros for the hash top-k expert router.
// ============================================================================
`ifndef HASH_TOPK_EXPERT_ROUTER_TOP_MACROS_SVH
`define HASH_TOPK_EXPERT_ROUTER_TOP_MACROS_SVH

// same-cycle implication
`define HTR_ASSERT_SAME(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("router assertion failed");

// next-cycle implication
`define HTR_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("router assertion failed");

`endif

### hw/rtl/htr_pkg.sv
// ============================================================================
// htr_pkg
// Types and constants of the hash top-k expert router.
// ============================================================================
package htr_pkg;

    localparam int HASH_W    = 64;
    localparam int HALF_W    = 32;
    localparam int COUNT_W   = 9;
    localparam int SLOT_CW   = 4;
    localparam int COUNT_MAX = 2 ** COUNT_W - 1;
    localparam int SLOT_MAX  = 2 ** SLOT_CW - 1;

    typedef logic [HASH_W-1:0]  word_t;
    typedef logic [HALF_W-1:0]  half_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [SLOT_CW-1:0] slot_cnt_t;
    typedef logic [1:0]         mul_op_t;
    typedef logic [1:0]         cfg_idx_t;

    localparam word_t GOLDEN  = 64'h9E37_79B9_7F4A_7C15;
    localparam word_t MIX_A   = 64'hBF58_476D_1CE4_E5B9;
    localparam word_t MIX_B   = 64'h94D0_49BB_1331_11EB;
    localparam word_t GOLDEN2 = word_t'(GOLDEN + GOLDEN);

    localparam int SHIFT_0 = 30;
    localparam int SHIFT_1 = 27;
    localparam int SHIFT_2 = 31;

    localparam mul_op_t OP_POS  = 2'd0;
    localparam mul_op_t OP_SALT = 2'd1;
    localparam mul_op_t OP_MIXA = 2'd2;
    localparam mul_op_t OP_MIXB = 2'd3;

    localparam cfg_idx_t CFG_EXPERT_COUNT    = 2'd0;
    localparam cfg_idx_t CFG_SLOTS_PER_TOKEN = 2'd1;
    localparam cfg_idx_t CFG_HASH_SEED       = 2'd2;

    function automatic word_t mul_const(input mul_op_t op);
        word_t c;
        case (op)
            OP_POS:  c = GOLDEN;
            OP_SALT: c = MIX_A;
            OP_MIXA: c = MIX_A;
            OP_MIXB: c = MIX_B;
            default: c = MIX_B;
        endcase
        return c;
    endfunction

endpackage

### hw/rtl/hash_topk_expert_router_top.sv
// ============================================================================
// hash_topk_expert_router_top
// Routes each token to distinct experts by a splitmix64 hash reduced modulo
// the expert count, rehashing with a larger salt on a collision.
//
//   channel | direction | payload
//   in      | request   | token_code, position
//   out     | result    | expert, slot, last (one per slot, last on final)
//   cfg     | write     | cfg_index, cfg_data
//
// One shared 32x32 multiplier runs every 64-bit product as four partial
// steps plus a dispatch step; a one-bit-per-cycle unit reduces the hash.
// Per token: position product, then per attempt the salt and mix products,
// reduction and collision check; per slot a result load, waiting while full.
// in_ready is high only between tokens. Reset sets expert_count 8,
// slots_per_token 1, hash_seed 0; there is no clearing pass.
// ============================================================================
`include "hash_topk_expert_router_top_macros.svh"

module hash_topk_expert_router_top #(
    parameter int MAX_EXPERTS = 256,
    parameter int MAX_SLOTS   = 8
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] token_code,
    input  logic [31:0] position,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  expert,
    output logic [2:0]  slot,
    output logic        last,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int EXP_CAP    = (MAX_EXPERTS < htr_pkg::COUNT_MAX) ?
                                MAX_EXPERTS : htr_pkg::COUNT_MAX;
    localparam int SLOT_LIMIT = (MAX_SLOTS < htr_pkg::SLOT_MAX) ?
                                MAX_SLOTS : htr_pkg::SLOT_MAX;
    localparam int IDX_W      = (SLOT_LIMIT > 1) ? $clog2(SLOT_LIMIT) : 1;
    localparam int BIT_W      = $clog2(htr_pkg::HASH_W);

    localparam htr_pkg::count_t    EXP_LIMIT  = htr_pkg::count_t'(EXP_CAP);
    localparam htr_pkg::slot_cnt_t SLOT_LIM_V = htr_pkg::slot_cnt_t'(SLOT_LIMIT);
    localparam logic [BIT_W-1:0]   BIT_LAST   = BIT_W'(htr_pkg::HASH_W - 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL   = 3'd1;
    localparam logic [2:0] S_MOD   = 3'd2;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;

    localparam logic [2:0] PH_LO_LO   = 3'd0;
    localparam logic [2:0] PH_LO_HI   = 3'd1;
    localparam logic [2:0] PH_HI_LO   = 3'd2;
    localparam logic [2:0] PH_ADD     = 3'd3;
    localparam logic [2:0] PH_DISPATCH = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic [2:0]          phase_reg, phase_next;
    htr_pkg::mul_op_t    op_reg, op_next;
    htr_pkg::slot_cnt_t  k_reg, k_next;
    htr_pkg::slot_cnt_t  ktot_reg, ktot_next;
    htr_pkg::count_t     n_reg, n_next;
    logic [BIT_W-1:0]    bit_reg, bit_next;
    logic                out_valid_reg, out_valid_next;

    htr_pkg::count_t     expert_count_reg;
    htr_pkg::slot_cnt_t  slots_reg;
    htr_pkg::half_t      seed_reg;

    htr_pkg::word_t      x_reg, x_next;
    htr_pkg::word_t      acc_reg, acc_next;
    htr_pkg::word_t      prod_reg, prod_next;
    htr_pkg::word_t      posg_reg, posg_next;
    htr_pkg::half_t      salt_reg, salt_next;
    htr_pkg::half_t      tok_reg, tok_next;
    htr_pkg::count_t     rem_reg, rem_next;
    logic [7:0]          expert_reg, expert_next;
    logic [2:0]          slot_reg, slot_next;
    logic                last_reg, last_next;
    htr_pkg::count_t     chosen_reg [SLOT_LIMIT];

    htr_pkg::half_t      mul_a;
    htr_pkg::half_t      mul_b;
    htr_pkg::word_t      mul_prod;
    htr_pkg::word_t      y_const;
    htr_pkg::word_t      st_mix;
    htr_pkg::word_t      st_add;
    logic [htr_pkg::COUNT_W:0] mod_shift;
    logic [htr_pkg::COUNT_W:0] mod_diff;
    htr_pkg::count_t     n_eff;
    htr_pkg::slot_cnt_t  kt0;
    htr_pkg::slot_cnt_t  kt1;
    htr_pkg::slot_cnt_t  kt_eff;
    htr_pkg::slot_cnt_t  k_inc;
    htr_pkg::slot_cnt_t  ktot_step;
    logic                taken;
    logic                out_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign expert    = expert_reg;
    assign slot      = slot_reg;
    assign last      = last_reg;

    assign y_const  = htr_pkg::mul_const(op_reg);
    assign mul_prod = mul_a * mul_b;
    assign st_mix   = {seed_reg, tok_reg} ^ posg_reg ^ acc_reg;
    assign st_add   = st_mix + htr_pkg::GOLDEN2;
    assign mod_shift = {rem_reg, x_reg[htr_pkg::HASH_W-1]};
    assign mod_diff  = mod_shift - {1'b0, n_reg};
    assign k_inc     = k_reg + 1'b1;
    assign ktot_step = ktot_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        case (phase_reg)
            PH_LO_LO:
            begin
                mul_a = x_reg[31:0];
                mul_b = y_const[31:0];
            end
            PH_LO_HI:
            begin
                mul_a = x_reg[31:0];
                mul_b = y_const[63:32];
            end
            default:
            begin
                mul_a = x_reg[63:32];
                mul_b = y_const[31:0];
            end
        endcase
    end

    always_comb
    begin
        if (expert_count_reg == '0)
            n_eff = htr_pkg::count_t'(1);
        else if (expert_count_reg > EXP_LIMIT)
            n_eff = EXP_LIMIT;
        else
            n_eff = expert_count_reg;
        kt0 = (slots_reg == '0) ? htr_pkg::slot_cnt_t'(1) : slots_reg;
        kt1 = (kt0 > SLOT_LIM_V) ? SLOT_LIM_V : kt0;
        if ({{(htr_pkg::COUNT_W - htr_pkg::SLOT_CW){1'b0}}, kt1} > n_eff)
            kt_eff = n_eff[htr_pkg::SLOT_CW-1:0];
        else
            kt_eff = kt1;
    end

    always_comb
    begin
        taken = 1'b0;
        for (int j = 0; j < SLOT_LIMIT; j++)
        begin
            if ((htr_pkg::slot_cnt_t'(j) < k_reg) && (chosen_reg[j] == rem_reg))
                taken = 1'b1;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        op_next        = op_reg;
        k_next         = k_reg;
        ktot_next      = ktot_reg;
        n_next         = n_reg;
        bit_next       = bit_reg;
        out_valid_next = out_valid_reg;
        x_next         = x_reg;
        acc_next       = acc_reg;
        prod_next      = prod_reg;
        posg_next      = posg_reg;
        salt_next      = salt_reg;
        tok_next       = tok_reg;
        rem_next       = rem_reg;
        expert_next    = expert_reg;
        slot_next      = slot_reg;
        last_next      = last_reg;

        if (out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    tok_next   = token_code;
                    x_next     = {32'b0, position};
                    op_next    = htr_pkg::OP_POS;
                    phase_next = PH_LO_LO;
                    salt_next  = '0;
                    k_next     = '0;
                    n_next     = n_eff;
                    ktot_next  = kt_eff;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                case (phase_reg)
                    PH_LO_LO:
                    begin
                        prod_next  = mul_prod;
                        phase_next = PH_LO_HI;
                    end
                    PH_LO_HI:
                    begin
                        acc_next   = prod_reg;
                        prod_next  = mul_prod;
                        phase_next = PH_HI_LO;
                    end
                    PH_HI_LO:
                    begin
                        acc_next   = {acc_reg[63:32] + prod_reg[31:0], acc_reg[31:0]};
                        prod_next  = mul_prod;
                        phase_next = PH_ADD;
                    end
                    PH_ADD:
                    begin
                        acc_next   = {acc_reg[63:32] + prod_reg[31:0], acc_reg[31:0]};
                        phase_next = PH_DISPATCH;
                    end
                    default:
                    begin
                        phase_next = PH_LO_LO;
                        case (op_reg)
                            htr_pkg::OP_POS:
                            begin
                                posg_next = acc_reg;
                                x_next    = {32'b0, salt_reg};
                                op_next   = htr_pkg::OP_SALT;
                            end
                            htr_pkg::OP_SALT:
                            begin
                                x_next  = st_add ^ (st_add >> htr_pkg::SHIFT_0);
                                op_next = htr_pkg::OP_MIXA;
                            end
                            htr_pkg::OP_MIXA:
                            begin
                                x_next  = acc_reg ^ (acc_reg >> htr_pkg::SHIFT_1);
                                op_next = htr_pkg::OP_MIXB;
                            end
                            default:
                            begin
                                x_next     = acc_reg ^ (acc_reg >> htr_pkg::SHIFT_2);
                                rem_next   = '0;
                                bit_next   = '0;
                                state_next = S_MOD;
                            end
                        endcase
                    end
                endcase
            end
            S_MOD:
            begin
                if (mod_shift >= {1'b0, n_reg})
                    rem_next = mod_diff[htr_pkg::COUNT_W-1:0];
                else
                    rem_next = mod_shift[htr_pkg::COUNT_W-1:0];
                x_next   = x_reg << 1;
                bit_next = bit_reg + 1'b1;
                if (bit_reg == BIT_LAST)
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (taken)
                begin
                    salt_next  = salt_reg + {28'b0, ktot_step};
                    x_next     = {32'b0, salt_reg + {28'b0, ktot_step}};
                    op_next    = htr_pkg::OP_SALT;
                    phase_next = PH_LO_LO;
                    state_next = S_MUL;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    expert_next    = rem_reg[7:0];
                    slot_next      = k_reg[2:0];
                    last_next      = (k_inc == ktot_reg);
                    if (k_inc == ktot_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        k_next     = k_inc;
                        salt_next  = {28'b0, k_inc};
                        x_next     = {60'b0, k_inc};
                        op_next    = htr_pkg::OP_SALT;
                        phase_next = PH_LO_LO;
                        state_next = S_MUL;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            phase_reg        <= PH_LO_LO;
            op_reg           <= htr_pkg::OP_POS;
            k_reg            <= '0;
            ktot_reg         <= htr_pkg::slot_cnt_t'(1);
            n_reg            <= htr_pkg::count_t'(1);
            bit_reg          <= '0;
            out_valid_reg    <= 1'b0;
            expert_count_reg <= htr_pkg::count_t'(8);
            slots_reg        <= htr_pkg::slot_cnt_t'(1);
            seed_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            op_reg        <= op_next;
            k_reg         <= k_next;
            ktot_reg      <= ktot_next;
            n_reg         <= n_next;
            bit_reg       <= bit_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    htr_pkg::CFG_EXPERT_COUNT:    expert_count_reg <= cfg_data[8:0];
                    htr_pkg::CFG_SLOTS_PER_TOKEN: slots_reg        <= cfg_data[3:0];
                    htr_pkg::CFG_HASH_SEED:       seed_reg         <= cfg_data;
                    default:                      ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg      <= x_next;
        acc_reg    <= acc_next;
        prod_reg   <= prod_next;
        posg_reg   <= posg_next;
        salt_reg   <= salt_next;
        tok_reg    <= tok_next;
        rem_reg    <= rem_next;
        expert_reg <= expert_next;
        slot_reg   <= slot_next;
        last_reg   <= last_next;
        if ((state_reg == S_CHECK) && !taken)
            chosen_reg[k_reg[IDX_W-1:0]] <= rem_reg;
    end

    `HTR_ASSERT_SAME(a_rem_in_range, clk, rst_n, (state_reg == S_CHECK), (rem_reg < n_reg))
    `HTR_ASSERT_SAME(a_slot_in_range, clk, rst_n, (state_reg != S_IDLE), (k_reg < ktot_reg))
    `HTR_ASSERT_SAME(a_ktot_valid, clk, rst_n, (state_reg != S_IDLE), ((ktot_reg != '0) && ({5'b0, ktot_reg} <= n_reg)))
    `HTR_ASSERT_NEXT(a_free_to_emit, clk, rst_n, ((state_reg == S_CHECK) && !taken), (state_reg == S_EMIT))

endmodule
